[design/rsmt_pkg.sv]
// shared types, constants and operation codes of the return-site tracker
`timescale 1ns / 1ps

package rsmt_pkg;

	localparam int DEF_NUM_SITES = 256;
	localparam int DEF_TARGETS   = 4;

	localparam int CNT_W    = 32;
	localparam int MEGA_W   = 9;
	localparam int SITE_CNT_W = 9;
	localparam int HELD_OUT_W = 3;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] MEGA_MAX = CNT_W'({MEGA_W{1'b1}});
	localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(16);

	localparam logic [CFG_IDX_W-1:0] REG_SITE_COUNT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MISS_THRESHOLD = 1'b1;

	typedef enum logic [1:0] {
		OP_INC,
		OP_EQ,
		OP_GE
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
	} alu_req_t;

endpackage

[design/return_site_megamorphic_tracker.sv]
// top level of the return-site megamorphic tracker
//
// a miss report (site_id, target_addr) is taken at a rising edge with start high and
// busy low. one result follows, shown for a single cycle with done high; the receiver
// cannot hold it off. saturating counts and the range, target and threshold checks
// go through one shared unit, stepped by a small sequencer; busy stays high until the
// result is shown. an index not below the site count, capped at NUM_SITES, is answered
// in the cycle after acceptance and busy stays low. a valid site reads its entry,
// counts the observation, searches the held targets, adds the target if unseen and
// there is room, checks the threshold, and a site turning megamorphic is counted; then
// its bypass counters are bumped one after another; an already megamorphic site skips
// the search. done rises in the cycle that busy falls. the per-site counters live in a
// ram, all entries zeroed after reset by a clearing pass, busy high; targets are not.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready; write
// only while the block is idle. site_count resets to 0, miss_threshold to 16.
`timescale 1ns / 1ps

module return_site_megamorphic_tracker import rsmt_pkg::*; #(
	parameter int NUM_SITES        = DEF_NUM_SITES,
	parameter int TARGETS_PER_SITE = DEF_TARGETS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [CNT_W-1:0]      site_id,
	input  logic [CNT_W-1:0]      target_addr,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CNT_W-1:0]      cfg_data,
	output logic                  done,
	output logic                  action,
	output logic [CNT_W-1:0]      site_misses,
	output logic [CNT_W-1:0]      site_bypasses,
	output logic [HELD_OUT_W-1:0] site_targets_held,
	output logic [CNT_W-1:0]      total_observations,
	output logic [MEGA_W-1:0]     megamorphic_sites,
	output logic [CNT_W-1:0]      total_bypasses
);

	localparam int SITE_AW   = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
	localparam int TGT_DEPTH = NUM_SITES * TARGETS_PER_SITE;
	localparam int TGT_AW    = (TGT_DEPTH > 1) ? $clog2(TGT_DEPTH) : 1;
	localparam int HELD_W    = $clog2(TARGETS_PER_SITE + 1);
	localparam int SITE_W    = 2 * CNT_W + 1 + HELD_W;

	localparam logic [HELD_W-1:0]  HELD_FULL = HELD_W'(TARGETS_PER_SITE);
	localparam logic [SITE_AW-1:0] LAST_SITE = SITE_AW'(NUM_SITES - 1);
	localparam logic [CNT_W-1:0]   SITE_LIM  = CNT_W'(NUM_SITES);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_READ  = 4'd2;
	localparam logic [3:0] S_OBS   = 4'd3;
	localparam logic [3:0] S_SRCH  = 4'd4;
	localparam logic [3:0] S_INS   = 4'd5;
	localparam logic [3:0] S_THR   = 4'd6;
	localparam logic [3:0] S_MEGA  = 4'd7;
	localparam logic [3:0] S_BYP   = 4'd8;
	localparam logic [3:0] S_BYPT  = 4'd9;
	localparam logic [3:0] S_WB    = 4'd10;

	logic [3:0]            state_q;
	logic [SITE_AW-1:0]    clr_q;
	logic [SITE_CNT_W-1:0] site_count_q;
	logic [CNT_W-1:0]      miss_threshold_q;
	logic [CNT_W-1:0]      obs_total_q;
	logic [MEGA_W-1:0]     mega_total_q;
	logic [CNT_W-1:0]      byp_total_q;
	logic                  done_q;

	logic [SITE_AW-1:0]    idx_q;
	logic [CNT_W-1:0]      tgt_q;
	logic [TGT_AW-1:0]     base_q;
	logic [CNT_W-1:0]      miss_q;
	logic [CNT_W-1:0]      byp_q;
	logic                  mega_q;
	logic [HELD_W-1:0]     held_q;
	logic [HELD_W-1:0]     k_q;
	logic                  found_q;

	logic                  action_q;
	logic [CNT_W-1:0]      site_misses_q;
	logic [CNT_W-1:0]      site_bypasses_q;
	logic [HELD_OUT_W-1:0] site_held_q;
	logic [CNT_W-1:0]      total_obs_out_q;
	logic [MEGA_W-1:0]     mega_out_q;
	logic [CNT_W-1:0]      total_byp_out_q;

	logic [CNT_W-1:0]      limit;
	alu_req_t              alu_req;
	logic [CNT_W-1:0]      alu_result;
	logic                  alu_flag;

	logic                  site_we;
	logic [SITE_AW-1:0]    site_waddr;
	logic [SITE_W-1:0]     site_wdata;
	logic [SITE_AW-1:0]    site_raddr;
	logic [SITE_W-1:0]     site_rdata;

	logic                  tgt_we;
	logic [TGT_AW-1:0]     tgt_waddr;
	logic [TGT_AW-1:0]     tgt_raddr;
	logic [CNT_W-1:0]      tgt_rdata;
	logic [HELD_W-1:0]     k_next;
	logic [CNT_W-1:0]      held_ext;
	logic                  accept;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign k_next    = HELD_W'(k_q + 1'b1);
	assign held_ext  = CNT_W'(held_q);

	assign limit = (CNT_W'(site_count_q) > SITE_LIM) ? SITE_LIM : CNT_W'(site_count_q);

	// site word: {megamorphic, held, bypasses, misses}
	assign site_we    = (state_q == S_CLEAR) || (state_q == S_WB);
	assign site_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
	assign site_wdata = (state_q == S_CLEAR) ? '0 : {mega_q, held_q, byp_q, miss_q};
	assign site_raddr = (state_q == S_IDLE) ? site_id[SITE_AW-1:0] : idx_q;

	// during the search the next entry is fetched while the current one is compared
	assign tgt_raddr = base_q + TGT_AW'((state_q == S_SRCH) ? k_next : k_q);
	assign tgt_waddr = base_q + TGT_AW'(held_q);
	assign tgt_we    = (state_q == S_INS) && !found_q && (held_q < HELD_FULL);

	always_comb begin
		alu_req = '{op: OP_GE, a: site_id, b: limit};
		unique case (state_q)
			S_READ:  alu_req = '{op: OP_INC, a: site_rdata[CNT_W-1:0], b: CNT_MAX};
			S_OBS:   alu_req = '{op: OP_INC, a: obs_total_q, b: CNT_MAX};
			S_SRCH:  alu_req = '{op: OP_EQ, a: tgt_rdata, b: tgt_q};
			S_THR:   alu_req = '{op: OP_GE, a: miss_q, b: miss_threshold_q};
			S_MEGA:  alu_req = '{op: OP_INC, a: CNT_W'(mega_total_q), b: MEGA_MAX};
			S_BYP:   alu_req = '{op: OP_INC, a: byp_q, b: CNT_MAX};
			S_BYPT:  alu_req = '{op: OP_INC, a: byp_total_q, b: CNT_MAX};
			default: alu_req = '{op: OP_GE, a: site_id, b: limit};
		endcase
	end

	rsmt_alu u_alu (
		.req    (alu_req),
		.result (alu_result),
		.flag   (alu_flag)
	);

	rsmt_ram #(
		.WIDTH (SITE_W),
		.DEPTH (NUM_SITES)
	) u_site_ram (
		.clk   (clk),
		.we    (site_we),
		.waddr (site_waddr),
		.wdata (site_wdata),
		.raddr (site_raddr),
		.rdata (site_rdata)
	);

	rsmt_ram #(
		.WIDTH (CNT_W),
		.DEPTH (TGT_DEPTH)
	) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (tgt_waddr),
		.wdata (tgt_q),
		.raddr (tgt_raddr),
		.rdata (tgt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_CLEAR;
			clr_q            <= '0;
			site_count_q     <= '0;
			miss_threshold_q <= THRESHOLD_RESET;
			obs_total_q      <= '0;
			mega_total_q     <= '0;
			byp_total_q      <= '0;
			done_q           <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SITE_COUNT:     site_count_q <= cfg_data[SITE_CNT_W-1:0];
					REG_MISS_THRESHOLD: miss_threshold_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SITE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						if (alu_flag) begin
							// index out of range: answer at once
							done_q <= 1'b1;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_OBS;
				S_OBS: begin
					obs_total_q <= alu_result;
					if (mega_q) begin
						state_q <= S_BYP;
					end else if (held_q == '0) begin
						state_q <= S_INS;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (k_next >= held_q) begin
						state_q <= S_INS;
					end
				end
				S_INS: state_q <= S_THR;
				S_THR: begin
					if (alu_flag && held_q == HELD_FULL) begin
						state_q <= S_MEGA;
					end else begin
						state_q <= S_WB;
					end
				end
				S_MEGA: begin
					mega_total_q <= alu_result[MEGA_W-1:0];
					state_q      <= S_BYP;
				end
				S_BYP: state_q <= S_BYPT;
				S_BYPT: begin
					byp_total_q <= alu_result;
					state_q     <= S_WB;
				end
				S_WB: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				idx_q   <= site_id[SITE_AW-1:0];
				tgt_q   <= target_addr;
				base_q  <= TGT_AW'(site_id[SITE_AW-1:0]) * TGT_AW'(TARGETS_PER_SITE);
				k_q     <= '0;
				found_q <= 1'b0;
				if (start && alu_flag) begin
					action_q        <= 1'b0;
					site_misses_q   <= '0;
					site_bypasses_q <= '0;
					site_held_q     <= '0;
					total_obs_out_q <= obs_total_q;
					mega_out_q      <= mega_total_q;
					total_byp_out_q <= byp_total_q;
				end
			end
			S_READ: begin
				miss_q <= alu_result;
				byp_q  <= site_rdata[2*CNT_W-1:CNT_W];
				held_q <= site_rdata[2*CNT_W+HELD_W-1:2*CNT_W];
				mega_q <= site_rdata[SITE_W-1];
			end
			S_SRCH: begin
				found_q <= found_q | alu_flag;
				k_q     <= k_next;
			end
			S_INS: begin
				if (tgt_we) begin
					held_q <= HELD_W'(held_q + 1'b1);
				end
			end
			S_THR: begin
				if (alu_flag && held_q == HELD_FULL) begin
					mega_q <= 1'b1;
				end
			end
			S_BYP: byp_q <= alu_result;
			S_WB: begin
				action_q        <= mega_q;
				site_misses_q   <= miss_q;
				site_bypasses_q <= byp_q;
				site_held_q     <= (held_ext > CNT_W'(7)) ? HELD_OUT_W'(7) :
					held_ext[HELD_OUT_W-1:0];
				total_obs_out_q <= obs_total_q;
				mega_out_q      <= mega_total_q;
				total_byp_out_q <= byp_total_q;
			end
			default: ;
		endcase
	end

	assign done               = done_q;
	assign action             = action_q;
	assign site_misses        = site_misses_q;
	assign site_bypasses      = site_bypasses_q;
	assign site_targets_held  = site_held_q;
	assign total_observations = total_obs_out_q;
	assign megamorphic_sites  = mega_out_q;
	assign total_bypasses     = total_byp_out_q;

	// a result only follows an accepted word or the end of a valid site's sequence
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(accept) || $past(state_q == S_WB)))
		else $error("result without a matching word");

	// a bypass answer implies at least one megamorphic site and counted bypasses
	a_bypass_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && action) |-> (megamorphic_sites != '0 && site_bypasses != '0 &&
			total_bypasses != '0))
		else $error("bypass answered without megamorphic state");

	// a valid site always shows at least one miss
	a_valid_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(state_q == S_WB)) |-> (site_misses != '0 &&
			total_observations != '0))
		else $error("valid site answered with no miss counted");

endmodule

[design/rsmt_ram.sv]
// generic one-write one-read ram with registered read data
`timescale 1ns / 1ps

module rsmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/rsmt_alu.sv]
// shared saturating increment and compare unit
`timescale 1ns / 1ps

module rsmt_alu import rsmt_pkg::*; (
	input  alu_req_t         req,
	output logic [CNT_W-1:0] result,
	output logic             flag
);

	logic a_ge_b;

	assign a_ge_b = (req.a >= req.b);

	always_comb begin
		result = req.a;
		flag   = 1'b0;
		unique case (req.op)
			OP_INC: begin
				// b is the ceiling
				result = a_ge_b ? req.b : req.a + CNT_W'(1);
				flag   = a_ge_b;
			end
			OP_EQ: begin
				flag = (req.a == req.b);
			end
			OP_GE: begin
				flag = a_ge_b;
			end
			default: begin
				result = req.a;
				flag   = 1'b0;
			end
		endcase
	end

endmodule

[verif/miss_answer_checker.sv]
// answer checker for the return-site tracker: predicts every answer and compares it
`timescale 1ns / 1ps

module miss_answer_checker import rsmt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [CNT_W-1:0]      site_id,
	input  logic [CNT_W-1:0]      target_addr,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CNT_W-1:0]      cfg_data,
	input  logic                  done,
	input  logic                  action,
	input  logic [CNT_W-1:0]      site_misses,
	input  logic [CNT_W-1:0]      site_bypasses,
	input  logic [HELD_OUT_W-1:0] site_targets_held,
	input  logic [CNT_W-1:0]      total_observations,
	input  logic [MEGA_W-1:0]     megamorphic_sites,
	input  logic [CNT_W-1:0]      total_bypasses,
	output int                    outstanding,
	output int                    mismatches,
	output int                    bypass_answers
);

	localparam int SITES    = DEF_NUM_SITES;
	localparam int SLOTS    = DEF_TARGETS;
	localparam int MEGA_TOP = 511;
	localparam int HELD_TOP = 7;

	localparam logic ACT_PATCH  = 1'b0;
	localparam logic ACT_BYPASS = 1'b1;

	typedef struct packed {
		logic                  action;
		logic [CNT_W-1:0]      misses;
		logic [CNT_W-1:0]      bypasses;
		logic [HELD_OUT_W-1:0] held;
		logic [CNT_W-1:0]      observations;
		logic [MEGA_W-1:0]     mega_sites;
		logic [CNT_W-1:0]      all_bypasses;
	} answer_t;

	answer_t expected_answers[$];

	logic [SITE_CNT_W-1:0] sites_in_use;
	logic [CNT_W-1:0]      threshold;

	logic [CNT_W-1:0] site_miss[SITES];
	logic [CNT_W-1:0] site_byp[SITES];
	bit               site_mega[SITES];
	int unsigned      site_held[SITES];
	logic [CNT_W-1:0] site_tgt[SITES*SLOTS];

	logic [CNT_W-1:0] obs_total;
	logic [CNT_W-1:0] byp_total;
	int unsigned      mega_total;

	int err_cnt = 0;
	int byp_cnt = 0;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	// updates the tracking state for one miss report and builds its answer
	task automatic predict_answer(input logic [CNT_W-1:0] idx, input logic [CNT_W-1:0] tgt,
			output answer_t a);
		int unsigned lim;
		int unsigned n;
		bit seen;
		lim = (sites_in_use > SITES) ? SITES : sites_in_use;
		a = '0;
		a.action = ACT_PATCH;
		if (idx < lim) begin
			obs_total = bump(obs_total);
			site_miss[idx] = bump(site_miss[idx]);
			if (!site_mega[idx]) begin
				n = site_held[idx];
				seen = 1'b0;
				for (int k = 0; k < n && k < SLOTS; k++)
					if (site_tgt[idx*SLOTS + k] === tgt)
						seen = 1'b1;
				if (!seen && n < SLOTS) begin
					site_tgt[idx*SLOTS + n] = tgt;
					site_held[idx] = n + 1;
				end
				// zero threshold needs no special case: the count is already at least one
				if (site_miss[idx] >= threshold && site_held[idx] >= SLOTS) begin
					site_mega[idx] = 1'b1;
					if (mega_total < MEGA_TOP)
						mega_total++;
				end
			end
			if (site_mega[idx]) begin
				a.action = ACT_BYPASS;
				byp_total = bump(byp_total);
				site_byp[idx] = bump(site_byp[idx]);
			end
			a.misses = site_miss[idx];
			a.bypasses = site_byp[idx];
			a.held = HELD_OUT_W'((site_held[idx] > HELD_TOP) ? HELD_TOP : site_held[idx]);
		end
		a.observations = obs_total;
		a.mega_sites = MEGA_W'(mega_total);
		a.all_bypasses = byp_total;
	endtask

	task automatic compare_field(input string name, input logic [CNT_W-1:0] want_v,
			input logic [CNT_W-1:0] got_v);
		if (want_v !== got_v) begin
			err_cnt++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		answer_t want;
		if (!arst_n) begin
			expected_answers.delete();
			sites_in_use = '0;
			threshold = THRESHOLD_RESET;
			for (int s = 0; s < SITES; s++) begin
				site_miss[s] = '0;
				site_byp[s] = '0;
				site_mega[s] = 1'b0;
				site_held[s] = 0;
			end
			obs_total = '0;
			byp_total = '0;
			mega_total = 0;
		end else begin
			// the answer for an earlier word may share an edge with the next acceptance
			if (done) begin
				if (expected_answers.size() == 0) begin
					err_cnt++;
					$display("%0t: answer with nothing pending, action %0h site_misses %0h",
						$time, action, site_misses);
				end else begin
					want = expected_answers.pop_front();
					compare_field("action", want.action, action);
					compare_field("site_misses", want.misses, site_misses);
					compare_field("site_bypasses", want.bypasses, site_bypasses);
					compare_field("site_targets_held", want.held, site_targets_held);
					compare_field("total_observations", want.observations,
						total_observations);
					compare_field("megamorphic_sites", want.mega_sites, megamorphic_sites);
					compare_field("total_bypasses", want.all_bypasses, total_bypasses);
					if (action === ACT_BYPASS)
						byp_cnt++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SITE_COUNT)
					sites_in_use = cfg_data[SITE_CNT_W-1:0];
				else if (cfg_index == REG_MISS_THRESHOLD)
					threshold = cfg_data;
			end
			if (start && !busy) begin
				predict_answer(site_id, target_addr, want);
				expected_answers.push_back(want);
			end
		end
		outstanding <= expected_answers.size();
		mismatches <= err_cnt;
		bypass_answers <= byp_cnt;
	end

endmodule

[verif/return_site_megamorphic_tracker_test.sv]
// testbench top for the return-site tracker: reset, register settings and miss traffic
`timescale 1ns / 1ps

module return_site_megamorphic_tracker_test;
	import rsmt_pkg::*;

	localparam int PHASES      = 4;
	localparam int PHASE_ITEMS = 125;
	localparam int SITES       = DEF_NUM_SITES;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [CNT_W-1:0]      site_id = '0;
	logic [CNT_W-1:0]      target_addr = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CNT_W-1:0]      cfg_data = '0;
	logic                  done;
	logic                  action;
	logic [CNT_W-1:0]      site_misses;
	logic [CNT_W-1:0]      site_bypasses;
	logic [HELD_OUT_W-1:0] site_targets_held;
	logic [CNT_W-1:0]      total_observations;
	logic [MEGA_W-1:0]     megamorphic_sites;
	logic [CNT_W-1:0]      total_bypasses;

	int outstanding;
	int mismatches;
	int bypass_answers;

	int idle_pct = 0;
	int sent = 0;
	int writes = 0;
	int unsigned cur_limit = 0;

	return_site_megamorphic_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.site_id(site_id),
		.target_addr(target_addr),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.action(action),
		.site_misses(site_misses),
		.site_bypasses(site_bypasses),
		.site_targets_held(site_targets_held),
		.total_observations(total_observations),
		.megamorphic_sites(megamorphic_sites),
		.total_bypasses(total_bypasses)
	);

	miss_answer_checker answers (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.site_id(site_id),
		.target_addr(target_addr),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.action(action),
		.site_misses(site_misses),
		.site_bypasses(site_bypasses),
		.site_targets_held(site_targets_held),
		.total_observations(total_observations),
		.megamorphic_sites(megamorphic_sites),
		.total_bypasses(total_bypasses),
		.outstanding(outstanding),
		.mismatches(mismatches),
		.bypass_answers(bypass_answers)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	// start stays high into the next word unless the sender decides to idle
	task automatic send_report(input logic [CNT_W-1:0] idx, input logic [CNT_W-1:0] tgt);
		start <= 1'b1;
		site_id <= idx;
		target_addr <= tgt;
		do @(posedge clk); while (busy);
		sent++;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold off until every answer is back and the block is idle
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
	endtask

	task automatic program_regs(input logic [CNT_W-1:0] sites, input logic [CNT_W-1:0] thr);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_SITE_COUNT;
		cfg_data <= sites;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_MISS_THRESHOLD;
		cfg_data <= thr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		writes += 2;
		cur_limit = (sites[SITE_CNT_W-1:0] > SITES) ? SITES : sites[SITE_CNT_W-1:0];
	endtask

	initial begin : stimulus
		int left;
		int run;
		int unsigned site;
		logic [CNT_W-1:0] base;
		logic [CNT_W-1:0] sites_val;
		logic [CNT_W-1:0] thr_val;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// no sites in use straight after reset: everything answers patch
		settle();
		send_report('0, '0);
		send_report(CNT_MAX, CNT_MAX);

		// upper bits of the site count are dropped; zero threshold behaves as one
		program_regs(32'hFFFF_FE04, '0);
		send_report(3, 32'h0000_000A);
		send_report(3, 32'h0000_000B);
		send_report(3, 32'h0000_000A);
		send_report(3, 32'h0000_000C);
		send_report(3, 32'h0000_000D);
		send_report(3, 32'h0000_000E);
		send_report(4, '0);
		send_report(0, '0);
		send_report(0, CNT_MAX);

		// site count above the table size is clamped; top threshold never trips
		program_regs(32'h0000_01FF, CNT_MAX);
		for (int k = 1; k <= 5; k++)
			send_report(SITES - 1, k);
		send_report(SITES, 32'h0000_0007);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: begin
				sites_val = SITES;
				thr_val = 1;
				idle_pct = 0;
			end
			1: begin
				sites_val = {$urandom} & ~32'h1FF | $urandom_range(1, 300);
				thr_val = $urandom_range(2, 8);
				idle_pct = 77;
			end
			2: begin
				sites_val = 8;
				thr_val = THRESHOLD_RESET;
				idle_pct = 0;
			end
			default: begin
				sites_val = SITES - 1;
				thr_val = $urandom_range(1, 6);
				idle_pct = 8;
			end
			endcase
			program_regs(sites_val, thr_val);

			left = PHASE_ITEMS;
			while (left > 0) begin
				if (cur_limit != 0 && $urandom_range(99) < 80) begin
					// a run of misses on one site drawn from a small set of targets
					site = $urandom_range(cur_limit - 1);
					base = $urandom;
					run = $urandom_range(3, 10);
					repeat (run)
						send_report(site, base + $urandom_range(5));
					left -= run;
				end else begin
					case ($urandom_range(2))
					0: send_report($urandom, $urandom);
					1: send_report(cur_limit + $urandom_range(3), $urandom);
					default: send_report($urandom_range(SITES - 1), $urandom);
					endcase
					left--;
				end
				if ($urandom_range(39) == 0)
					settle();
			end
		end

		settle();
		repeat (20) @(posedge clk);
		$display("covered %0d miss reports and %0d register writes over %0d traffic phases",
			sent, writes, PHASES);
		$display("%0d answers were bypass, the rest patch", bypass_answers);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
